[rtl/nrtm_pkg.sv]
package nrtm_pkg;

    // Width of the reported index field
    localparam int IDX_OUT_W = 10;

    typedef enum logic
    {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

endpackage

[rtl/nrtm_if.sv]
interface nrtm_in_if #(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [TIME_BITS-1:0] stamp;
    logic                 first;

    modport source (output valid, output func, output stamp, output first, input ready);
    modport sink   (input valid, input func, input stamp, input first, output ready);
endinterface

interface nrtm_out_if;
    logic                           valid;
    logic                           ready;
    logic [nrtm_pkg::IDX_OUT_W-1:0] nearest_index;
    logic                           found;
    logic                           truncated;

    modport source (output valid, output nearest_index, output found, output truncated,
                    input ready);
    modport sink   (input valid, input nearest_index, input found, input truncated,
                    output ready);
endinterface

[rtl/nrtm_sub.sv]
module nrtm_sub #(
    parameter int W = 48
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         borrow
);

    // borrow set means a < b
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

[rtl/nrtm_ram.sv]
module nrtm_ram #(
    parameter int DEPTH = 1024,
    parameter int W     = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/nearest_reference_time_matcher.sv]
// Channel  Role    Transfer carries
// -------  ------  ---------------------------------------------
// item     sink    func, stamp, first
// result   source  nearest_index, found, truncated (one per query)
//
// Load: no result. Query: ends in S_IDLE when the list holds at most one reference or
// the pointer sits at the last one; else S_WALK steps the pointer up, then S_LO and S_DIF
// follow; S_LO ends it for a query below the lower reference, S_WALK when the walk runs
// off the end. One registered memory read port and one shared subtractor serve all steps.
// A finished result waits in the output register; a second one stalls the input until sent.
// rst_n clears count, walk pointer, overflow flag and control; memory is not cleared.
module nearest_reference_time_matcher #(
    parameter int REF_DEPTH = 1024,
    parameter int TIME_BITS = 48
) (
    input  logic       clk,
    input  logic       rst_n,
    nrtm_in_if.sink    item,
    nrtm_out_if.source result
);

    localparam int IDX_W = $clog2(REF_DEPTH);
    localparam int CNT_W = $clog2(REF_DEPTH + 1);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_WALK,
        S_LO,
        S_DIF,
        S_OUT
    } state_t;

    state_t               state_reg,     state_next;
    logic [IDX_W-1:0]     wp_reg,        wp_next;
    logic [CNT_W-1:0]     count_reg,     count_next;
    logic                 ovf_reg,       ovf_next;
    logic [TIME_BITS-1:0] t_reg,         t_next;
    logic [TIME_BITS-1:0] hi_dist_reg,   hi_dist_next;
    logic [TIME_BITS-1:0] lo_dist_reg,   lo_dist_next;
    logic [IDX_W-1:0]     res_reg,       res_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_idx_reg,   out_idx_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_trunc_reg, out_trunc_next;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [IDX_W-1:0]     raddr;
    logic [TIME_BITS-1:0] rdata;
    logic [TIME_BITS-1:0] sub_a;
    logic [TIME_BITS-1:0] sub_b;
    logic [TIME_BITS-1:0] sub_diff;
    logic                 sub_borrow;

    nrtm_ram #(
        .DEPTH (REF_DEPTH),
        .W     (TIME_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (item.stamp),
        .raddr (raddr),
        .rdata (rdata)
    );

    nrtm_sub #(
        .W (TIME_BITS)
    ) u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign item.ready           = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.nearest_index = nrtm_pkg::IDX_OUT_W'(out_idx_reg);
    assign result.found         = out_found_reg;
    assign result.truncated     = out_trunc_reg;

    always_comb
    begin
        logic [CNT_W-1:0] last;
        logic [IDX_W-1:0] wp_eff;
        logic [CNT_W-1:0] cnt_eff;
        logic [IDX_W-1:0] wp_inc;
        logic             slot_free;
        logic             fin;
        logic [IDX_W-1:0] fin_idx;
        logic             out_load;
        logic [IDX_W-1:0] out_load_idx;

        state_next     = state_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        t_next         = t_reg;
        hi_dist_next   = hi_dist_reg;
        lo_dist_next   = lo_dist_reg;
        res_next       = res_reg;
        out_idx_next   = out_idx_reg;
        out_found_next = out_found_reg;
        out_trunc_next = out_trunc_reg;

        last         = count_reg - CNT_W'(1);
        wp_eff       = wp_reg;
        cnt_eff      = count_reg;
        wp_inc       = wp_reg + IDX_W'(1);
        slot_free    = !out_valid_reg || result.ready;
        fin          = 1'b0;
        fin_idx      = wp_reg;
        out_load     = 1'b0;
        out_load_idx = res_reg;
        we           = 1'b0;
        waddr        = count_reg[IDX_W-1:0];
        raddr        = wp_reg;
        sub_a        = '0;
        sub_b        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    t_next = item.stamp;
                    if (item.func == nrtm_pkg::FUNC_LOAD)
                    begin
                        if (item.first)
                        begin
                            cnt_eff  = '0;
                            wp_next  = '0;
                            ovf_next = 1'b0;
                        end
                        waddr = cnt_eff[IDX_W-1:0];
                        if (cnt_eff < CNT_W'(REF_DEPTH))
                        begin
                            we         = 1'b1;
                            count_next = cnt_eff + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next   = 1'b1;
                            count_next = cnt_eff;
                        end
                    end
                    else
                    begin
                        if (item.first)
                        begin
                            wp_eff = '0;
                        end
                        wp_next = wp_eff;
                        raddr   = wp_eff + IDX_W'(1);
                        if (count_reg <= CNT_W'(1))
                        begin
                            fin     = 1'b1;
                            fin_idx = '0;
                        end
                        else if (CNT_W'(wp_eff) >= last)
                        begin
                            fin     = 1'b1;
                            fin_idx = last[IDX_W-1:0];
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_WALK:
            begin
                // rdata holds the reference just above the pointer
                sub_a = rdata;
                sub_b = t_reg;
                if (sub_borrow)
                begin
                    wp_next = wp_inc;
                    raddr   = wp_inc + IDX_W'(1);
                    if (CNT_W'(wp_inc) >= last)
                    begin
                        fin     = 1'b1;
                        fin_idx = last[IDX_W-1:0];
                    end
                end
                else
                begin
                    hi_dist_next = sub_diff;
                    raddr        = wp_reg;
                    state_next   = S_LO;
                end
            end

            S_LO:
            begin
                sub_a = t_reg;
                sub_b = rdata;
                if (sub_borrow)
                begin
                    // query below the lower reference: lower index wins
                    fin     = 1'b1;
                    fin_idx = wp_reg;
                end
                else
                begin
                    lo_dist_next = sub_diff;
                    state_next   = S_DIF;
                end
            end

            S_DIF:
            begin
                sub_a   = hi_dist_reg;
                sub_b   = lo_dist_reg;
                fin     = 1'b1;
                fin_idx = sub_borrow ? wp_inc : wp_reg;
            end

            S_OUT:
            begin
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    out_load_idx = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (slot_free)
            begin
                out_load     = 1'b1;
                out_load_idx = fin_idx;
                state_next   = S_IDLE;
            end
            else
            begin
                res_next   = fin_idx;
                state_next = S_OUT;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = out_load_idx;
            out_found_next = (count_reg != '0);
            out_trunc_next = ovf_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            t_reg         <= '0;
            hi_dist_reg   <= '0;
            lo_dist_reg   <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_found_reg <= 1'b0;
            out_trunc_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            t_reg         <= t_next;
            hi_dist_reg   <= hi_dist_next;
            lo_dist_reg   <= lo_dist_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_found_reg <= out_found_next;
            out_trunc_reg <= out_trunc_next;
        end
    end

endmodule
